// File: sv/gmhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmhs_pkg
// Shared types and constants for the gzip member header stripper.
// ----------------------------------------------------------------------------
package gmhs_pkg;

  // Body bytes held back so the CRC32/ISIZE trailer never leaves the block
  localparam int TRAILER_BYTES = 8;
  localparam int DLY_DEPTH     = (TRAILER_BYTES > 0) ? TRAILER_BYTES : 1;
  localparam int FILL_W        = (TRAILER_BYTES > 0) ? $clog2(TRAILER_BYTES + 1) : 1;

  // Header constants
  localparam logic [7:0] ID_FIRST       = 8'h1f;
  localparam logic [7:0] ID_SECOND      = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam int         MIN_MEMBER     = 18;
  localparam int         FIXED_SKIP     = 6;
  localparam int         CNT_W          = 5;

  // Flag bits as kept in flags_r of gmhs_parse (byte bits 1..4)
  localparam int FLG_HCRC    = 0;
  localparam int FLG_EXTRA   = 1;
  localparam int FLG_NAME    = 2;
  localparam int FLG_COMMENT = 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_MAGIC = 2'd2
  } status_t;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic [1:0] status;
    logic       run_end;
  } result_t;

  // Parser -> delay line
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       clear;
  } dly_ctl_t;

  // Delay line -> parser / output
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       payload_any;
  } dly_stat_t;

endpackage

// File: sv/gmhs_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmhs_delay
// Shift line that holds the newest body bytes; once full, each new body
// byte pushes out the oldest one as a deflate payload byte.
// ----------------------------------------------------------------------------
module gmhs_delay
  import gmhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dly_ctl_t  ctl,
  output dly_stat_t stat
);

  logic [7:0]        taps_r [DLY_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              pay_any_r, pay_any_nxt;
  logic              full;

  assign full = (fill_r == FILL_W'(TRAILER_BYTES));

  // Emission: oldest tap leaves when the line is full
  always_comb begin
    stat.emit        = ctl.push && full;
    stat.data        = (TRAILER_BYTES == 0) ? ctl.data : taps_r[0];
    stat.payload_any = pay_any_r;
  end

  // Fill count and payload-seen flag
  always_comb begin
    fill_nxt    = fill_r;
    pay_any_nxt = pay_any_r;
    if (ctl.push) begin
      if (full) pay_any_nxt = 1'b1;
      else      fill_nxt    = fill_r + 1'b1;
    end
    if (ctl.clear) begin
      fill_nxt    = '0;
      pay_any_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      pay_any_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      pay_any_r <= pay_any_nxt;
    end
  end

  // Tap shift, newest byte enters at the tail
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < DLY_DEPTH - 1; i++) taps_r[i] <= taps_r[i+1];
      taps_r[DLY_DEPTH-1] <= ctl.data;
    end
  end

endmodule

// File: sv/gmhs_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmhs_parse
// Header state machine: ID/method check, flag capture, skipping of the
// fixed part, extra field, name, comment and header CRC; end status.
// ----------------------------------------------------------------------------
module gmhs_parse
  import gmhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] data_byte,
  input  logic      final_byte,
  input  dly_stat_t dstat,
  output dly_ctl_t  dctl,
  output status_t   end_status
);

  typedef enum logic [12:0] {
    PH_ID0     = 13'b0000000000001,
    PH_ID1     = 13'b0000000000010,
    PH_METHOD  = 13'b0000000000100,
    PH_FLAGS   = 13'b0000000001000,
    PH_FIXED   = 13'b0000000010000,
    PH_XLEN_LO = 13'b0000000100000,
    PH_XLEN_HI = 13'b0000001000000,
    PH_EXTRA   = 13'b0000010000000,
    PH_NAME    = 13'b0000100000000,
    PH_COMMENT = 13'b0001000000000,
    PH_HCRC    = 13'b0010000000000,
    PH_BODY    = 13'b0100000000000,
    PH_DISCARD = 13'b1000000000000
  } phase_t;

  // Where the next optional-part search starts
  typedef enum logic [1:0] {
    FROM_XLEN    = 2'd0,
    FROM_NAME    = 2'd1,
    FROM_COMMENT = 2'd2,
    FROM_HCRC    = 2'd3
  } from_t;

  phase_t            phase_r, phase_nxt, phase_upd;
  logic [CNT_W-1:0]  total_r, total_nxt, total_upd;
  logic [15:0]       skip_r, skip_nxt, skip_upd, skip_dec;
  logic [3:0]        flags_r, flags_nxt, flags_upd;
  logic              bad_r, bad_nxt, bad_upd;

  // First optional part at or after the start point that the flags ask for
  function automatic phase_t pick(from_t from, logic [3:0] fl);
    phase_t ph;
    ph = PH_BODY;
    if (from == FROM_XLEN && fl[FLG_EXTRA])
      ph = PH_XLEN_LO;
    else if ((from == FROM_XLEN || from == FROM_NAME) && fl[FLG_NAME])
      ph = PH_NAME;
    else if (from != FROM_HCRC && fl[FLG_COMMENT])
      ph = PH_COMMENT;
    else if (fl[FLG_HCRC])
      ph = PH_HCRC;
    return ph;
  endfunction

  assign skip_dec = skip_r - 16'd1;

  // Per-byte state update
  always_comb begin
    phase_upd = phase_r;
    skip_upd  = skip_r;
    flags_upd = flags_r;
    bad_upd   = bad_r;
    total_upd = (total_r == '1) ? total_r : total_r + 1'b1;

    unique case (phase_r)
      PH_ID0: begin
        if (data_byte != ID_FIRST) bad_upd = 1'b1;
        phase_upd = PH_ID1;
      end
      PH_ID1: begin
        if (data_byte != ID_SECOND) bad_upd = 1'b1;
        phase_upd = PH_METHOD;
      end
      PH_METHOD: begin
        if (data_byte != METHOD_DEFLATE) bad_upd = 1'b1;
        phase_upd = (bad_r || data_byte != METHOD_DEFLATE) ? PH_DISCARD : PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_upd = data_byte[4:1];
        skip_upd  = 16'(FIXED_SKIP);
        phase_upd = PH_FIXED;
      end
      PH_FIXED: begin
        skip_upd = skip_dec;
        if (skip_dec == 16'd0) phase_upd = pick(FROM_XLEN, flags_r);
      end
      PH_XLEN_LO: begin
        skip_upd  = {8'd0, data_byte};
        phase_upd = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_upd  = {data_byte, skip_r[7:0]};
        phase_upd = ({data_byte, skip_r[7:0]} == 16'd0) ? pick(FROM_NAME, flags_r)
                                                         : PH_EXTRA;
      end
      PH_EXTRA: begin
        skip_upd = skip_dec;
        if (skip_dec == 16'd0) phase_upd = pick(FROM_NAME, flags_r);
      end
      PH_NAME: begin
        if (data_byte == 8'd0) phase_upd = pick(FROM_COMMENT, flags_r);
      end
      PH_COMMENT: begin
        if (data_byte == 8'd0) phase_upd = pick(FROM_HCRC, flags_r);
      end
      PH_HCRC: begin
        skip_upd = skip_dec;
        if (skip_dec == 16'd0) phase_upd = PH_BODY;
      end
      PH_BODY:    ;
      PH_DISCARD: ;
      default:    phase_upd = PH_ID0;
    endcase

    // Header CRC always skips two bytes
    if (phase_upd == PH_HCRC && phase_r != PH_HCRC) skip_upd = 16'd2;
  end

  // Delay line control
  always_comb begin
    dctl.push  = take && (phase_r == PH_BODY);
    dctl.data  = data_byte;
    dctl.clear = take && final_byte;
  end

  // Closing status: length first, then magic, then body with payload
  always_comb begin
    if (total_upd < CNT_W'(MIN_MEMBER))
      end_status = ST_SHORT;
    else if (bad_upd)
      end_status = ST_MAGIC;
    else if (phase_upd == PH_BODY && (dstat.payload_any || dstat.emit))
      end_status = ST_OK;
    else
      end_status = ST_SHORT;
  end

  // Commit on transfer; last byte returns everything to reset values
  always_comb begin
    phase_nxt = phase_r;
    total_nxt = total_r;
    skip_nxt  = skip_r;
    flags_nxt = flags_r;
    bad_nxt   = bad_r;
    if (take) begin
      if (final_byte) begin
        phase_nxt = PH_ID0;
        total_nxt = '0;
        skip_nxt  = '0;
        flags_nxt = '0;
        bad_nxt   = 1'b0;
      end else begin
        phase_nxt = phase_upd;
        total_nxt = total_upd;
        skip_nxt  = skip_upd;
        flags_nxt = flags_upd;
        bad_nxt   = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID0;
      total_r <= '0;
      skip_r  <= '0;
      flags_r <= '0;
      bad_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      skip_r  <= skip_nxt;
      flags_r <= flags_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// File: sv/gmhs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmhs_outq
// Four-entry result queue; takes up to two results per cycle and hands
// out one per transfer.
// ----------------------------------------------------------------------------
module gmhs_outq
  import gmhs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr0,
  input  result_t wr0_data,
  input  logic    wr1,
  input  result_t wr1_data,
  output logic    room2,
  output logic    rd_valid,
  output result_t rd_data,
  input  logic    rd_take
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  result_t         ent_r [QD];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic [1:0]      nwr;

  assign room2    = (cnt_r <= (PW+1)'(QD - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = ent_r[rp_r];

  // Pointer and count update
  always_comb begin
    nwr     = {1'b0, wr0} + {1'b0, wr1};
    wp_nxt  = wp_r + PW'(nwr);
    rp_nxt  = rd_take ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(nwr) - (PW+1)'(rd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (wr0) ent_r[wp_r] <= wr0_data;
    if (wr1) ent_r[wp_r + 1'b1] <= wr1_data;
  end

endmodule

// File: sv/gzip_member_header_stripper_unit.sv
`timescale 1ns / 1ps
// A byte's results are registered in the queue on its transfer and reach out_*
// behind older ones; a status queued after a payload byte follows once it is taken.
// Throughput: one byte per cycle while in_stall is low; the last byte of a member
// with a payload byte yields two results, drained one per cycle while out_stall is
// low from a four-entry queue. in_stall rises when fewer than two entries are free.
// Reset (rst_n low, synchronous) returns the parser to the first ID byte and
// empties the delay line and the queue.
// ----------------------------------------------------------------------------
// gzip_member_header_stripper_unit
// Strips the gzip member header and trailer, emitting raw deflate bytes and a
// closing status per member.
// ----------------------------------------------------------------------------
module gzip_member_header_stripper_unit
  import gmhs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_is_payload,
  output logic [1:0] out_status,
  output logic       out_run_end
);

  dly_ctl_t  dctl;
  dly_stat_t dstat;
  status_t   end_status;
  logic      take, room2;
  result_t   pay_res, st_res, w0_data, head;
  logic      w0, w1;

  assign in_stall = !room2;
  assign take     = in_valid && room2;

  gmhs_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .dstat      (dstat),
    .dctl       (dctl),
    .end_status (end_status)
  );

  gmhs_delay u_delay (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .stat  (dstat)
  );

  // Result assembly: payload byte first, then status on the last byte
  always_comb begin
    pay_res.payload_byte = dstat.data;
    pay_res.is_payload   = 1'b1;
    pay_res.status       = ST_OK;
    pay_res.run_end      = 1'b0;

    st_res.payload_byte  = 8'd0;
    st_res.is_payload    = 1'b0;
    st_res.status        = end_status;
    st_res.run_end       = 1'b1;

    w0      = take && (dstat.emit || in_final_byte);
    w0_data = dstat.emit ? pay_res : st_res;
    w1      = take && dstat.emit && in_final_byte;
  end

  gmhs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0      (w0),
    .wr0_data (w0_data),
    .wr1      (w1),
    .wr1_data (st_res),
    .room2    (room2),
    .rd_valid (out_valid),
    .rd_data  (head),
    .rd_take  (out_valid && !out_stall)
  );

  assign out_payload_byte = head.payload_byte;
  assign out_is_payload   = head.is_payload;
  assign out_status       = head.status;
  assign out_run_end      = head.run_end;

endmodule
